FILE: hdl/sitda_pkg.sv
package sitda_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_DIGITS  = 10;

    localparam int BCD_W = MAX_DIGITS * 4;
    localparam int CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
    localparam int REM_W = $clog2(MAX_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
    localparam logic [3:0] BCD_ADJ       = 4'd3;

    typedef logic [BCD_W-1:0]       t_bcd;
    typedef logic [VALUE_WIDTH-1:0] t_mag;

endpackage

FILE: hdl/signed_int_to_decimal_ascii.sv
// signed integer to decimal ascii text
//
// input channel: i_valid / o_ready with i_value, a signed two's complement
// integer. output channel: o_valid / i_ready with o_ascii_char and o_last,
// one transaction per character, most significant digit first, a leading
// '-' for negative values and o_last high on the final digit.
//
// an accepted value goes through a shift-and-add-3 binary to bcd converter,
// one input bit per cycle, then moves to a separate character emitter.
// o_ready rises again once the result has moved to the emitter, so a new
// value can be taken while the previous text is sent. the emitter drops
// leading zeros at one digit per cycle, then sends one character per cycle
// while the receiver takes them.
//
// synchronous active-low reset empties the converter, the emitter and
// the output register. when the receiver stalls, the output register
// holds its character, the emitter waits, and the converter holds its
// result, so o_ready stays low until the emitter can take it.
module signed_int_to_decimal_ascii
    import sitda_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [7:0]             o_ascii_char,
    output logic                   o_last
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RUN  = 2'd1;
    localparam logic [1:0] C_DONE = 2'd2;

    localparam logic [1:0] E_IDLE = 2'd0;
    localparam logic [1:0] E_SKIP = 2'd1;
    localparam logic [1:0] E_OUT  = 2'd2;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);
    localparam logic [REM_W-1:0] REM_FULL = REM_W'(MAX_DIGITS);
    localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);

    logic [1:0]       r_cstate, n_cstate;
    t_mag             r_shift, n_shift;
    t_bcd             r_bcd, n_bcd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_neg, n_neg;

    logic [1:0]       r_estate, n_estate;
    t_bcd             r_ebcd, n_ebcd;
    logic [REM_W-1:0] r_erem, n_erem;
    logic             r_eminus, n_eminus;

    logic             r_ovalid, n_ovalid;
    logic [7:0]       r_ochar, n_ochar;
    logic             r_olast, n_olast;

    t_bcd             bcd_adj;
    t_mag             in_mag;
    logic             in_accept;
    logic             handoff;
    logic             out_free;
    logic [3:0]       top_digit;

    assign in_accept = i_valid && o_ready;
    assign handoff   = (r_cstate == C_DONE) && (r_estate == E_IDLE);
    assign out_free  = !r_ovalid || i_ready;
    assign top_digit = r_ebcd[BCD_W-1 -: 4];
    assign in_mag    = i_value[VALUE_WIDTH-1] ? (~i_value + t_mag'(1)) : i_value;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= BCD_ADJ_LIMIT) begin
                bcd_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + BCD_ADJ;
            end else begin
                bcd_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    always_comb begin
        n_cstate = r_cstate;
        n_shift  = r_shift;
        n_bcd    = r_bcd;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        unique case (r_cstate)
            C_IDLE: begin
                if (in_accept) begin
                    n_shift  = in_mag;
                    n_bcd    = '0;
                    n_cnt    = '0;
                    n_neg    = i_value[VALUE_WIDTH-1];
                    n_cstate = C_RUN;
                end
            end
            C_RUN: begin
                n_bcd   = {bcd_adj[BCD_W-2:0], r_shift[VALUE_WIDTH-1]};
                n_shift = r_shift << 1;
                n_cnt   = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_cstate = C_DONE;
                end
            end
            C_DONE: begin
                if (handoff) begin
                    n_cstate = C_IDLE;
                end
            end
            default: begin
                n_cstate = C_IDLE;
            end
        endcase
    end

    always_comb begin
        n_estate = r_estate;
        n_ebcd   = r_ebcd;
        n_erem   = r_erem;
        n_eminus = r_eminus;
        n_ovalid = r_ovalid && !i_ready;
        n_ochar  = r_ochar;
        n_olast  = r_olast;
        unique case (r_estate)
            E_IDLE: begin
                if (handoff) begin
                    n_ebcd   = r_bcd;
                    n_erem   = REM_FULL;
                    n_eminus = r_neg;
                    n_estate = E_SKIP;
                end
            end
            E_SKIP: begin
                // drop leading zeros, keep at least one digit
                if ((top_digit == 4'd0) && (r_erem != REM_ONE)) begin
                    n_ebcd = r_ebcd << 4;
                    n_erem = r_erem - REM_ONE;
                end else begin
                    n_estate = E_OUT;
                end
            end
            E_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    if (r_eminus) begin
                        n_ochar  = CHAR_MINUS;
                        n_olast  = 1'b0;
                        n_eminus = 1'b0;
                    end else begin
                        n_ochar = CHAR_ZERO + {4'd0, top_digit};
                        n_olast = (r_erem == REM_ONE);
                        n_ebcd  = r_ebcd << 4;
                        n_erem  = r_erem - REM_ONE;
                        if (r_erem == REM_ONE) begin
                            n_estate = E_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_estate = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cstate <= C_IDLE;
            r_estate <= E_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_cstate <= n_cstate;
            r_estate <= n_estate;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift  <= n_shift;
        r_bcd    <= n_bcd;
        r_cnt    <= n_cnt;
        r_neg    <= n_neg;
        r_ebcd   <= n_ebcd;
        r_erem   <= n_erem;
        r_eminus <= n_eminus;
        r_ochar  <= n_ochar;
        r_olast  <= n_olast;
    end

    assign o_ready      = (r_cstate == C_IDLE);
    assign o_valid      = r_ovalid;
    assign o_ascii_char = r_ochar;
    assign o_last       = r_olast;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_cstate == C_RUN) && (r_cnt == '0))
        else $error("conversion did not start after accepted transaction");

    a_handoff_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        handoff |=> (r_estate == E_SKIP) && (r_erem == REM_FULL) && (r_cstate == C_IDLE))
        else $error("converter result not moved to emitter");

    a_emit_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_estate == E_OUT) |-> (r_erem != '0))
        else $error("emitter running with no digits left");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_ascii_char == CHAR_MINUS)) |-> !o_last)
        else $error("minus sign flagged as last character");

endmodule
